// File: src/quadrant_beam_tracker_core_assert.svh
// Assertion macros for the tracker RTL.
`ifndef QUADRANT_BEAM_TRACKER_CORE_ASSERT_SVH
`define QUADRANT_BEAM_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define QBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define QBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/qbt_pkg.sv
// ----------------------------------------------------------------------------
// qbt_pkg
// Widths, register indexes, sequencer states and the quarter-wave trig tables.
// ----------------------------------------------------------------------------
package qbt_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int ANGLE_STEPS    = 1024;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int ANGLE_BITS = $clog2(ANGLE_STEPS);
  localparam int QUARTER    = ANGLE_STEPS / 4;
  localparam int QTR_BITS   = ANGLE_BITS - 2;
  localparam int TRIG_W     = TRIG_FRAC_BITS + 1;
  localparam int SPEED_W    = 16;
  localparam int PROD_W     = TRIG_W + SPEED_W;
  localparam int SCALE_SH   = TRIG_FRAC_BITS - 8;
  localparam int POS_W      = 48;
  localparam int OUT_W      = 32;
  localparam int ERR_W      = 11;
  localparam int ERR_LIMIT  = 1023;
  localparam int GRADE_W    = 8;
  localparam int DIVR_W     = 8;
  localparam int LEVEL_W    = 10;
  localparam int NUM_W      = 20;
  localparam int MAG_W      = NUM_W - 1;
  localparam int DEN_W      = GRADE_W + 1;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_GRADE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_H = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_V = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVH_GO, S_DIVH_WAIT, S_DIVV_GO, S_DIVV_WAIT, S_ROM,
    S_MUL_S, S_MUL_C, S_CVT, S_APPLY_V, S_APPLY_H, S_DONE
  } qbt_state_t;

  typedef logic [TRIG_W-1:0] trig_rom_t [QUARTER];

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint PIHALF_Q30 = 64'sd1686629713;
  localparam int     TRIG_SH    = 30 - TRIG_FRAC_BITS;

  function automatic logic [TRIG_W-1:0] to_trig(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > Q30_ONE) c = Q30_ONE;
    c = (c + (64'sd1 <<< (TRIG_SH - 1))) >>> TRIG_SH;
    return c[TRIG_W-1:0];
  endfunction

  function automatic trig_rom_t build_rom(bit cosine);
    trig_rom_t rom;
    longint x;
    longint x2;
    longint t;
    for (int r = 0; r < QUARTER; r++) begin
      x  = (PIHALF_Q30 * longint'(r * 4)) / ANGLE_STEPS;
      x2 = (x * x) / Q30_ONE;
      if (cosine) begin
        t = Q30_ONE;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 182;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 132;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 90;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 56;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 30;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 12;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 2;
        rom[r] = to_trig(t);
      end else begin
        t = Q30_ONE;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 156;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 110;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 72;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 42;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 20;
        t = Q30_ONE - ((x2 * t) / Q30_ONE) / 6;
        rom[r] = to_trig((x * t) / Q30_ONE);
      end
    end
    return rom;
  endfunction

  localparam trig_rom_t SIN_ROM = build_rom(1'b0);
  localparam trig_rom_t COS_ROM = build_rom(1'b1);

endpackage

// File: src/qbt_if.sv
// ----------------------------------------------------------------------------
// qbt_sample_if / qbt_target_if
// Valid/ready channels for diode samples in and stepper targets out.
// ----------------------------------------------------------------------------
interface qbt_sample_if;
  logic                             valid;
  logic                             ready;
  logic [qbt_pkg::SAMPLE_BITS-1:0]  diode_left_up;
  logic [qbt_pkg::SAMPLE_BITS-1:0]  diode_left_down;
  logic [qbt_pkg::SAMPLE_BITS-1:0]  diode_right_up;
  logic [qbt_pkg::SAMPLE_BITS-1:0]  diode_right_down;
  logic [qbt_pkg::ANGLE_BITS-1:0]   disc_angle;
  modport source (output valid, diode_left_up, diode_left_down, diode_right_up,
                  diode_right_down, disc_angle, input ready);
  modport sink (input valid, diode_left_up, diode_left_down, diode_right_up,
                diode_right_down, disc_angle, output ready);
endinterface

interface qbt_target_if;
  logic                             valid;
  logic                             ready;
  logic signed [qbt_pkg::OUT_W-1:0] step_target_h;
  logic signed [qbt_pkg::OUT_W-1:0] step_target_v;
  logic                             targets_updated;
  logic signed [qbt_pkg::ERR_W-1:0] error_h_smoothed;
  logic signed [qbt_pkg::ERR_W-1:0] error_v_smoothed;
  modport source (output valid, step_target_h, step_target_v, targets_updated,
                  error_h_smoothed, error_v_smoothed, input ready);
  modport sink (input valid, step_target_h, step_target_v, targets_updated,
                error_h_smoothed, error_v_smoothed, output ready);
endinterface

// File: src/qbt_div.sv
// ----------------------------------------------------------------------------
// qbt_div
// Radix-2 restoring divider, signed numerator, truncation toward zero,
// result clamped to the filter range.
// ----------------------------------------------------------------------------
module qbt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [qbt_pkg::NUM_W-1:0]    num,
  input  logic        [qbt_pkg::DEN_W-1:0]    den,
  output logic                                done,
  output logic signed [qbt_pkg::ERR_W-1:0]    quot
);
  import qbt_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic                busy;
  logic [CNT_W-1:0]    count;
  logic                neg;
  logic [MAG_W-1:0]    mag;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    divisor;
  logic [DEN_W:0]      trial;
  logic                fits;
  logic [NUM_W-1:0]    num_abs;
  logic [ERR_W-1:0]    clamped;

  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : num;
  assign trial   = {rem, mag[MAG_W-1]};
  assign fits    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(MAG_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[NUM_W-1];
      mag     <= num_abs[MAG_W-1:0];
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      mag <= {mag[MAG_W-2:0], fits};
    end
  end

  assign clamped = (mag > MAG_W'(ERR_LIMIT)) ? ERR_W'(ERR_LIMIT) : mag[ERR_W-1:0];
  assign quot    = neg ? -$signed(clamped) : $signed(clamped);

endmodule

// File: src/quadrant_beam_tracker_core.sv
// ----------------------------------------------------------------------------
// quadrant_beam_tracker_core
// Quadrant photodiode beam tracker: smoothed errors, trig-scaled steps,
// Q32.16 stepper position accumulators.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  samples   in   valid/ready           four diode samples, disc angle
//  targets   out  valid/ready           step targets, tick flag, errors
//  wr_*      in   wr_en, no back-press  register index and data
//
//  One item at a time: an accept step in S_IDLE, two serial divisions (H, then V)
//  on the shared divider, the ROM, multiply, convert and apply steps on a tick,
//  and a last step in S_DONE to load the result.
//  Reset (rst, sync) restores register defaults, clears FSM and tracker state.
//  A result waiting on targets stalls the block in its last step.
// ----------------------------------------------------------------------------
`include "quadrant_beam_tracker_core_assert.svh"

module quadrant_beam_tracker_core (
  input  logic                                clk,
  input  logic                                rst,
  qbt_sample_if.sink                          samples,
  qbt_target_if.source                        targets,
  input  logic                                wr_en,
  input  logic [qbt_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [qbt_pkg::REG_DATA_W-1:0]      wr_data
);
  import qbt_pkg::*;

  qbt_state_t state, state_next;

  logic [GRADE_W-1:0]       filter_grade;
  logic [DIVR_W-1:0]        loop_divider;
  logic [LEVEL_W-1:0]       trigger_level;
  logic [SPEED_W-1:0]       speed_h;
  logic [SPEED_W-1:0]       speed_v;

  logic [DIVR_W-1:0]        tick_counter;
  logic signed [ERR_W-1:0]  filt_h;
  logic signed [ERR_W-1:0]  filt_v;
  logic [POS_W-1:0]         pos_h;
  logic [POS_W-1:0]         pos_v;

  logic signed [ERR_W-1:0]  err_h;
  logic signed [ERR_W-1:0]  err_v;
  logic [ANGLE_BITS-1:0]    angle;
  logic                     tick;
  logic [TRIG_W-1:0]        sn_mag;
  logic [TRIG_W-1:0]        cs_mag;
  logic                     sn_neg;
  logic                     cs_neg;
  logic [PROD_W-1:0]        prod;
  logic [POS_W-1:0]         step_s;
  logic [POS_W-1:0]         step_c;

  logic                     accept;
  logic [DIVR_W-1:0]        cnt_inc;
  logic [DIVR_W-1:0]        div_eff;
  logic                     tick_now;
  logic [SAMPLE_BITS-1:0]   max_l, max_r, max_u, max_d;

  logic                     div_start;
  logic                     div_done;
  logic signed [NUM_W-1:0]  div_num;
  logic signed [ERR_W-1:0]  div_quot;
  logic signed [ERR_W-1:0]  filt_old;
  logic signed [ERR_W-1:0]  err_new;

  logic [1:0]               quad;
  logic [TRIG_W-1:0]        rom_s, rom_c;
  logic [TRIG_W-1:0]        mul_a;
  logic [SPEED_W-1:0]       mul_b;
  logic                     mul_neg;
  logic [PROD_W:0]          rounded;
  logic [POS_W-1:0]         step_mag;
  logic [POS_W-1:0]         step_now;
  logic signed [LEVEL_W+1:0] lvl;
  logic signed [LEVEL_W+1:0] lvl_neg;
  logic [POS_W-1:0]         adj_h, adj_v;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_grade  <= GRADE_W'(4);
      loop_divider  <= DIVR_W'(1);
      trigger_level <= LEVEL_W'(16);
      speed_h       <= SPEED_W'(256);
      speed_v       <= SPEED_W'(256);
    end else if (wr_en) begin
      case (wr_index)
        REG_GRADE:   filter_grade  <= wr_data[GRADE_W-1:0];
        REG_DIVIDER: loop_divider  <= wr_data[DIVR_W-1:0];
        REG_LEVEL:   trigger_level <= wr_data[LEVEL_W-1:0];
        REG_SPEED_H: speed_h       <= wr_data[SPEED_W-1:0];
        REG_SPEED_V: speed_v       <= wr_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;

  assign max_l = (samples.diode_left_up > samples.diode_left_down) ?
                 samples.diode_left_up : samples.diode_left_down;
  assign max_r = (samples.diode_right_up > samples.diode_right_down) ?
                 samples.diode_right_up : samples.diode_right_down;
  assign max_u = (samples.diode_left_up > samples.diode_right_up) ?
                 samples.diode_left_up : samples.diode_right_up;
  assign max_d = (samples.diode_left_down > samples.diode_right_down) ?
                 samples.diode_left_down : samples.diode_right_down;

  assign cnt_inc  = tick_counter + 1'b1;
  assign div_eff  = (loop_divider == '0) ? DIVR_W'(1) : loop_divider;
  assign tick_now = cnt_inc >= div_eff;

  // shared divider: (old * grade + new) / (grade + 1)
  assign filt_old  = (state == S_DIVH_GO) ? filt_h : filt_v;
  assign err_new   = (state == S_DIVH_GO) ? err_h : err_v;
  assign div_num   = NUM_W'(filt_old) * $signed({{(NUM_W-GRADE_W){1'b0}}, filter_grade})
                     + NUM_W'(err_new);
  assign div_start = (state == S_DIVH_GO) || (state == S_DIVV_GO);

  qbt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (DEN_W'(filter_grade) + 1'b1),
    .done  (div_done),
    .quot  (div_quot)
  );

  // quarter-wave lookup and shared scaling multiplier
  assign quad    = angle[ANGLE_BITS-1 -: 2];
  assign rom_s   = SIN_ROM[angle[QTR_BITS-1:0]];
  assign rom_c   = COS_ROM[angle[QTR_BITS-1:0]];
  assign mul_a   = (state == S_MUL_S) ? sn_mag : cs_mag;
  assign mul_b   = (state == S_MUL_S) ? speed_h : speed_v;
  assign mul_neg = (state == S_MUL_C) ? sn_neg : cs_neg;
  assign rounded = ({1'b0, prod} + (PROD_W + 1)'(1 << (SCALE_SH - 1))) >> SCALE_SH;
  assign step_mag = POS_W'(rounded);
  assign step_now = mul_neg ? -step_mag : step_mag;

  assign lvl     = $signed({2'b00, trigger_level});
  assign lvl_neg = -lvl;

  assign adj_h = pos_h + (pos_h[POS_W-1] ? POS_W'(16'hFFFF) : '0);
  assign adj_v = pos_v + (pos_v[POS_W-1] ? POS_W'(16'hFFFF) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_DIVH_GO;
      S_DIVH_GO:   state_next = S_DIVH_WAIT;
      S_DIVH_WAIT: if (div_done) state_next = S_DIVV_GO;
      S_DIVV_GO:   state_next = S_DIVV_WAIT;
      S_DIVV_WAIT: if (div_done) state_next = tick ? S_ROM : S_DONE;
      S_ROM:       state_next = S_MUL_S;
      S_MUL_S:     state_next = S_MUL_C;
      S_MUL_C:     state_next = S_CVT;
      S_CVT:       state_next = S_APPLY_V;
      S_APPLY_V:   state_next = S_APPLY_H;
      S_APPLY_H:   state_next = S_DONE;
      S_DONE:      if (!targets.valid || targets.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      filt_h       <= '0;
      filt_v       <= '0;
      pos_h        <= '0;
      pos_v        <= '0;
    end else begin
      if (accept) tick_counter <= tick_now ? '0 : cnt_inc;
      if (state == S_DIVH_WAIT && div_done) filt_h <= div_quot;
      if (state == S_DIVV_WAIT && div_done) filt_v <= div_quot;
      if (state == S_APPLY_V) begin
        if (filt_v > ERR_W'(lvl)) begin
          pos_v <= pos_v - step_c;
          pos_h <= pos_h + step_s;
        end else if ($signed({filt_v[ERR_W-1], filt_v}) < lvl_neg) begin
          pos_v <= pos_v + step_c;
          pos_h <= pos_h - step_s;
        end
      end
      if (state == S_APPLY_H) begin
        if ($signed({filt_h[ERR_W-1], filt_h}) > lvl) begin
          pos_h <= pos_h + step_c;
          pos_v <= pos_v + step_s;
        end else if ($signed({filt_h[ERR_W-1], filt_h}) < lvl_neg) begin
          pos_h <= pos_h - step_c;
          pos_v <= pos_v - step_s;
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      err_h <= $signed({1'b0, max_l}) - $signed({1'b0, max_r});
      err_v <= $signed({1'b0, max_u}) - $signed({1'b0, max_d});
      angle <= samples.disc_angle;
      tick  <= tick_now;
    end
    if (state == S_ROM) begin
      case (quad)
        2'd0: begin sn_mag <= rom_s; sn_neg <= 1'b0; cs_mag <= rom_c; cs_neg <= 1'b0; end
        2'd1: begin sn_mag <= rom_c; sn_neg <= 1'b0; cs_mag <= rom_s; cs_neg <= 1'b1; end
        2'd2: begin sn_mag <= rom_s; sn_neg <= 1'b1; cs_mag <= rom_c; cs_neg <= 1'b1; end
        default: begin
          sn_mag <= rom_c; sn_neg <= 1'b1; cs_mag <= rom_s; cs_neg <= 1'b0;
        end
      endcase
    end
    if (state == S_MUL_S || state == S_MUL_C) prod <= mul_a * mul_b;
    if (state == S_MUL_C) step_s <= step_now;
    if (state == S_CVT)   step_c <= step_now;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      targets.valid <= 1'b0;
    end else if (state == S_DONE && (!targets.valid || targets.ready)) begin
      targets.valid <= 1'b1;
    end else if (targets.ready) begin
      targets.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!targets.valid || targets.ready)) begin
      targets.step_target_h    <= $signed(adj_h[POS_W-1 -: OUT_W]);
      targets.step_target_v    <= $signed(adj_v[POS_W-1 -: OUT_W]);
      targets.targets_updated  <= tick;
      targets.error_h_smoothed <= filt_h;
      targets.error_v_smoothed <= filt_v;
    end
  end

  `QBT_ASSERT_NXT(a_counter_below_div, accept, tick_counter < div_eff)
  `QBT_ASSERT_IMP(a_done_in_wait, div_done, state == S_DIVH_WAIT || state == S_DIVV_WAIT)
  `QBT_ASSERT_NXT(a_filt_range, state == S_DIVV_WAIT && div_done, filt_v <= ERR_W'(ERR_LIMIT) && filt_v >= -ERR_W'(ERR_LIMIT))

endmodule
